// ===== hw/rtl/piuh_pkg.sv =====
package piuh_pkg;

  localparam int unsigned Colours = 256;
  localparam int unsigned IdxW    = $clog2(Colours);
  localparam int unsigned InIdxW  = 8;
  localparam int unsigned NameW   = 64;
  localparam int unsigned BinW    = 32;
  localparam int unsigned TotW    = 40;
  localparam int unsigned CntW    = 16;

  localparam logic [InIdxW:0] ColoursLim = (InIdxW + 1)'(Colours);

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PIXEL = 2'd1,
    OP_END   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // Request into the per-lump histogram memory.
  typedef struct packed {
    logic            pix;   // read-modify-write increment of one bin
    logic            walk;  // read one bin for the merge
    logic            clr;   // forget every bin
    logic [IdxW-1:0] addr;
  } hist_req_t;

  // Request into the per-index statistics memories.
  typedef struct packed {
    logic            walk;  // merge one bin into its statistics
    logic            rd;    // read the statistics of one index
    logic [IdxW-1:0] addr;
  } stats_req_t;

  typedef struct packed {
    logic [NameW-1:0] name;
    logic [CntW-1:0]  count;
    logic [TotW-1:0]  total;
  } stats_res_t;

endpackage

// ===== hw/rtl/palette_index_usage_histogram_core.sv =====
// Palette index usage histogram.
// Input words arrive on the s_axis channel: tuser carries the operation
// (begin lump, pixel, end lump, read index), tdata the palette index and
// the eight-byte lump name. Only read words give a result word on the
// m_axis channel, holding the total uses, the lump count and the name of
// the first lump that used the index.
// Pixel and begin words are taken one per cycle while the block is idle; a
// pixel updates its bin through a read-modify-write of the lump memory
// with forwarding. An end word walks all 256 bins through the statistics
// memory and blocks the input through the walk and a flush state. A read
// result passes through the statistics read register and then the output
// register; a new read waits while the one before is in the first of them.
// If the receiver stalls, pixel, begin and end words are still taken, and
// a read word waits until the output register is free.
// Reset clears the control state and the valid bits of both memories, so
// every bin and every statistic reads as zero at once, with no clearing
// pass.
module palette_index_usage_histogram_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // pixel_index[7:0], lump_id[71:8]
  input  logic [1:0]   s_axis_tuser,   // op[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // total_uses[39:0], lump_count[55:40],
                                       // first_lump_id[119:56], zero pad
);
  import piuh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e state_q, state_d;

  op_e               op;
  logic [InIdxW-1:0] in_idx;
  logic [NameW-1:0]  in_name;
  logic              idx_ok;
  logic              acc;
  logic              rd_slot;

  logic [IdxW-1:0]   walk_cnt_q, walk_cnt_d;
  logic              walk_last;
  logic [NameW-1:0]  cur_name_q;

  logic              s1_rd_q, s1_ok_q;
  logic              out_vld_q, out_vld_d;
  stats_res_t        out_q;

  hist_req_t         hist_req;
  stats_req_t        stats_req;
  logic [BinW-1:0]   bin;
  stats_res_t        res;
  logic [IdxW-1:0]   addr;

  assign op      = op_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[InIdxW-1:0];
  assign in_name = s_axis_tdata[InIdxW +: NameW];
  assign idx_ok  = {1'b0, in_idx} < ColoursLim;

  // A read may enter only when its result has a free output register.
  assign rd_slot       = !s1_rd_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE) && ((op != OP_READ) || rd_slot);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign walk_last = walk_cnt_q == IdxW'(Colours - 1);
  assign addr      = (state_q == ST_WALK) ? walk_cnt_q : in_idx[IdxW-1:0];

  always_comb begin
    hist_req.pix  = acc && (op == OP_PIXEL) && idx_ok;
    hist_req.walk = state_q == ST_WALK;
    hist_req.clr  = (acc && (op == OP_BEGIN)) || ((state_q == ST_WALK) && walk_last);
    hist_req.addr = addr;

    stats_req.walk = state_q == ST_WALK;
    stats_req.rd   = acc && (op == OP_READ) && idx_ok;
    stats_req.addr = addr;
  end

  piuh_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hist_req),
    .bin_o  (bin)
  );

  piuh_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (stats_req),
    .name_i (cur_name_q),
    .bin_i  (bin),
    .res_o  (res)
  );

  // The flush cycle lets the last merge write land before a read can see it.
  always_comb begin
    state_d    = state_q;
    walk_cnt_d = walk_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && (op == OP_END)) begin
          state_d    = ST_WALK;
          walk_cnt_d = '0;
        end
      end
      ST_WALK: begin
        walk_cnt_d = walk_cnt_q + IdxW'(1);
        if (walk_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (s1_rd_q) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      walk_cnt_q <= '0;
      cur_name_q <= '0;
      s1_rd_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      walk_cnt_q <= walk_cnt_d;
      if (acc && (op == OP_BEGIN)) begin
        cur_name_q <= in_name;
      end
      s1_rd_q   <= acc && (op == OP_READ);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ok_q <= idx_ok;
    if (s1_rd_q) begin
      out_q <= s1_ok_q ? res : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {8'b0, out_q.name, out_q.count, out_q.total};

endmodule

// ===== hw/rtl/piuh_hist.sv =====
module piuh_hist (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  piuh_pkg::hist_req_t       req_i,
  output logic [piuh_pkg::BinW-1:0] bin_o
);
  import piuh_pkg::*;

  logic [BinW-1:0] mem_q [Colours];
  logic [Colours-1:0] vld_q;

  logic [BinW-1:0] rd_q;
  logic            hv_q;
  logic            s1_pix_q;
  logic [IdxW-1:0] s1_addr_q;

  logic            fwd_vld_q, fwd_vld_d;
  logic [IdxW-1:0] fwd_addr_q;
  logic [BinW-1:0] fwd_bin_q;

  logic [BinW-1:0] base;
  logic [BinW-1:0] bin_inc;

  // A bin written in the previous cycle was read before that write landed,
  // so its new count is taken from the forwarding register.
  always_comb begin
    if (fwd_vld_q && (fwd_addr_q == s1_addr_q)) begin
      base = fwd_bin_q;
    end else if (hv_q) begin
      base = rd_q;
    end else begin
      base = '0;
    end
    bin_inc = (&base) ? base : base + BinW'(1);
  end

  assign fwd_vld_d = s1_pix_q && !req_i.clr;
  assign bin_o     = base;

  always_ff @(posedge clk_i) begin
    if (s1_pix_q) begin
      mem_q[s1_addr_q] <= bin_inc;
    end
    if (req_i.pix || req_i.walk) begin
      rd_q <= mem_q[req_i.addr];
      hv_q <= vld_q[req_i.addr];
    end
    s1_addr_q  <= req_i.addr;
    fwd_addr_q <= s1_addr_q;
    fwd_bin_q  <= bin_inc;
  end

  // Clearing wins over a write landing in the same cycle, which is the
  // order of the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      s1_pix_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (s1_pix_q) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
      if (req_i.clr) begin
        vld_q <= '0;
      end
      s1_pix_q  <= req_i.pix;
      fwd_vld_q <= fwd_vld_d;
    end
  end

endmodule

// ===== hw/rtl/piuh_stats.sv =====
module piuh_stats (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  piuh_pkg::stats_req_t       req_i,
  input  logic [piuh_pkg::NameW-1:0] name_i,
  input  logic [piuh_pkg::BinW-1:0]  bin_i,
  output piuh_pkg::stats_res_t       res_o
);
  import piuh_pkg::*;

  // One entry holds every statistic of an index, so a single memory serves.
  typedef struct packed {
    logic [NameW-1:0] nm;
    logic [CntW-1:0]  cnt;
    logic [TotW-1:0]  tot;
  } stat_t;

  stat_t              st_mem_q [Colours];
  logic [Colours-1:0] vld_q;

  stat_t            st_rd_q;
  logic             sv_q;
  logic             s1_walk_q;
  logic [IdxW-1:0]  s1_addr_q;

  logic [TotW-1:0]  tot_cur;
  logic [CntW-1:0]  cnt_cur;
  logic [TotW:0]    sum;
  stat_t            st_new;
  logic             merge;

  always_comb begin
    tot_cur = sv_q ? st_rd_q.tot : '0;
    cnt_cur = sv_q ? st_rd_q.cnt : '0;
    sum     = {1'b0, tot_cur} + (TotW + 1)'(bin_i);
    st_new.tot = sum[TotW] ? '1 : sum[TotW-1:0];
    st_new.cnt = (&cnt_cur) ? cnt_cur : cnt_cur + CntW'(1);
    st_new.nm  = (tot_cur == '0) ? name_i : st_rd_q.nm;
    merge   = s1_walk_q && (bin_i != '0);
  end

  assign res_o.total = tot_cur;
  assign res_o.count = cnt_cur;
  assign res_o.name  = (tot_cur != '0) ? st_rd_q.nm : '0;

  always_ff @(posedge clk_i) begin
    if (merge) begin
      st_mem_q[s1_addr_q] <= st_new;
    end
    if (req_i.walk || req_i.rd) begin
      st_rd_q <= st_mem_q[req_i.addr];
      sv_q    <= vld_q[req_i.addr];
    end
    s1_addr_q <= req_i.addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      s1_walk_q <= 1'b0;
    end else begin
      if (merge) begin
        vld_q[s1_addr_q] <= 1'b1;
      end
      s1_walk_q <= req_i.walk;
    end
  end

endmodule

// ===== tb/sv/tb_palette_index_usage_histogram_core.sv =====
module tb_palette_index_usage_histogram_core;
  import piuh_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned RandWords  = 850;
  localparam int unsigned LongHold   = 400;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  // Software copy of the block's statistics.
  logic [BinW-1:0]  lump_bins  [Colours];
  logic [TotW-1:0]  use_totals [Colours];
  logic [CntW-1:0]  use_lumps  [Colours];
  logic [NameW-1:0] first_names[Colours];
  logic [NameW-1:0] open_name;

  stats_res_t  pending_stats[$];
  int unsigned words_sent;
  int unsigned reads_checked;
  int unsigned lumps_closed;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned hold_left;
  bit          hold_request;
  bit          gaps_on;

  palette_index_usage_histogram_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a few cycles, now and then a long pause; none while gaps are off.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(10, 40);
    end
  endfunction

  task automatic apply_to_histogram(op_e op, logic [InIdxW-1:0] idx, logic [NameW-1:0] name);
    stats_res_t            res;
    logic [TotW:0]         sum;
    logic [IdxW-1:0]       i;
    int unsigned           n;
    case (op)
      OP_BEGIN: begin
        for (n = 0; n < Colours; n++) lump_bins[n] = '0;
        open_name = name;
      end
      OP_PIXEL: begin
        if (idx < Colours && lump_bins[idx] != '1) lump_bins[idx]++;
      end
      OP_END: begin
        for (n = 0; n < Colours; n++) begin
          i = n[IdxW-1:0];
          if (lump_bins[i] != '0) begin
            if (use_totals[i] == '0) first_names[i] = open_name;
            sum = {1'b0, use_totals[i]} + (TotW + 1)'(lump_bins[i]);
            use_totals[i] = sum[TotW] ? '1 : sum[TotW-1:0];
            if (use_lumps[i] != '1) use_lumps[i]++;
          end
        end
        for (n = 0; n < Colours; n++) lump_bins[n] = '0;
        lumps_closed++;
      end
      default: begin
        res = '0;
        if (idx < Colours) begin
          res.total = use_totals[idx];
          res.count = use_lumps[idx];
          res.name  = (use_totals[idx] != '0) ? first_names[idx] : '0;
        end
        pending_stats.push_back(res);
      end
    endcase
  endtask

  // Called and returning at a falling edge; tvalid stays high when no gap follows.
  task automatic send_word(op_e op, logic [InIdxW-1:0] idx, logic [NameW-1:0] name);
    int unsigned gap;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {name, idx};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    apply_to_histogram(op, idx, name);
    words_sent++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  function automatic logic [NameW-1:0] rand_name();
    return {$urandom, $urandom};
  endfunction

  // Receiver side: random stalls, plus a long hold when a test asks for one.
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LongHold;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    stats_res_t got;
    stats_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = stats_res_t'(m_axis_tdata[119:0]);
      reads_checked++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_stats.pop_front();
        if (got.total !== want.total || got.count !== want.count ||
            got.name !== want.name || m_axis_tdata[127:120] !== 8'h00) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: total %h/%h count %h/%h name %h/%h pad %h (exp/got)",
                     want.total, got.total, want.count, got.count,
                     want.name, got.name, m_axis_tdata[127:120]);
          end
        end
      end
    end
  end

  // Watchdog over cycles in which neither side moves a word.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic test_reset_reads();
    send_word(OP_READ, 8'd0, '0);
    send_word(OP_READ, 8'd255, '0);
  endtask

  // Pixels and an end with no begin are merged under the reset name of zero.
  task automatic test_orphan_lump();
    send_word(OP_PIXEL, 8'd0, '0);
    send_word(OP_PIXEL, 8'd255, '0);
    send_word(OP_PIXEL, 8'd255, '0);
    send_word(OP_END, 8'd0, '0);
    send_word(OP_READ, 8'd0, '0);
    send_word(OP_READ, 8'd255, '0);
  endtask

  task automatic test_named_lumps();
    send_word(OP_BEGIN, 8'd0, '1);
    send_word(OP_PIXEL, 8'd0, '0);
    send_word(OP_PIXEL, 8'd128, '0);
    send_word(OP_PIXEL, 8'd255, '1);
    send_word(OP_END, 8'd0, '0);
    send_word(OP_READ, 8'd0, '0);
    send_word(OP_READ, 8'd128, '0);
    send_word(OP_READ, 8'd7, '1);
  endtask

  // A second end adds nothing, and a begin throws away an open lump.
  task automatic test_repeated_end();
    send_word(OP_END, 8'd0, '0);
    send_word(OP_READ, 8'd128, '0);
    send_word(OP_BEGIN, 8'd0, 64'h0123_4567_89ab_cdef);
    send_word(OP_PIXEL, 8'd128, '0);
    send_word(OP_BEGIN, 8'd0, 64'ha5a5_5a5a_a5a5_5a5a);
    send_word(OP_END, 8'd0, '0);
    send_word(OP_READ, 8'd128, '0);
  endtask

  // The receiver holds off while reads and pixels keep coming, so the
  // output register fills and the input has to stall.
  task automatic test_backpressure();
    int unsigned k;
    gaps_on       = 1'b0;
    hold_request  = 1'b1;
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    send_word(OP_BEGIN, 8'd0, rand_name());
    for (k = 0; k < 12; k++) send_word(OP_PIXEL, 8'($urandom_range(0, 255)), '0);
    for (k = 0; k < 6; k++) send_word(OP_READ, 8'($urandom_range(0, 255)), '0);
    send_word(OP_END, 8'd0, '0);
    for (k = 0; k < 4; k++) send_word(OP_READ, 8'($urandom_range(0, 255)), '0);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_lumps();
    int unsigned     n;
    int unsigned     k;
    logic [7:0]      base;
    logic [7:0]      idx;
    while (words_sent < RandWords) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 8) begin
        send_word(OP_BEGIN, 8'($urandom), rand_name());
        n    = $urandom_range(1, 30);
        base = 8'($urandom);
        for (k = 0; k < n; k++) begin
          idx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : base + 8'($urandom_range(0, 7));
          if ($urandom_range(0, 9) == 0) begin
            send_word(OP_READ, idx, rand_name());
          end else begin
            send_word(OP_PIXEL, idx, rand_name());
          end
        end
        send_word(OP_END, 8'($urandom), rand_name());
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_word(OP_READ, base + 8'($urandom_range(0, 7)), '0);
      end else begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) begin
          send_word(op_e'($urandom_range(0, 3)), 8'($urandom), rand_name());
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    int unsigned n;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BEGIN;
    hold_request  = 1'b0;
    gaps_on       = 1'b1;
    words_sent    = 0;
    reads_checked = 0;
    lumps_closed  = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    for (n = 0; n < Colours; n++) begin
      lump_bins[n]   = '0;
      use_totals[n]  = '0;
      use_lumps[n]   = '0;
      first_names[n] = '0;
    end
    open_name = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_reads();
    test_orphan_lump();
    test_named_lumps();
    test_repeated_end();
    test_backpressure();
    test_random_lumps();
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d words, closed %0d lumps and checked %0d statistics reads,",
             words_sent, lumps_closed, reads_checked);
    $display("with random gaps on both sides and two long receiver hold-offs.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
